// File: rtl/core/pws_pkg.sv
// Shared types and constants for the perspective projection block
`default_nettype none
package pws_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int RATIO_BITS    = 40;
	// three front stages plus one queued transfer in steady flow; one slot spare
	localparam int MID_DEPTH     = 5;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 3;
	localparam int HALF_W        = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_XROW_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_XROW_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_YROW_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_YROW_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WROW_A = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WROW_B = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_W = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_H = 3'd7;

	localparam logic [HALF_W-1:0] HALF_W_RST = 15'd1280;
	localparam logic [HALF_W-1:0] HALF_H_RST = 15'd720;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
	} point_t;

	typedef struct packed {
		logic               visible;
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
	} pixel_t;

	// rows: x clip, y clip, depth; a = {y weight, x weight}, b = {offset, z weight}
	typedef struct packed {
		logic [CFG_DATA_W-1:0] xa;
		logic [CFG_DATA_W-1:0] xb;
		logic [CFG_DATA_W-1:0] ya;
		logic [CFG_DATA_W-1:0] yb;
		logic [CFG_DATA_W-1:0] wa;
		logic [CFG_DATA_W-1:0] wb;
	} coef_t;
endpackage
`default_nettype wire

// File: rtl/core/pws_fifo.sv
// Small register queue between the row evaluator and the divider
`default_nettype none
module pws_fifo import pws_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = MID_DEPTH,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  empty,
	output logic      [CW-1:0]    count
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(wr_en) - CW'(rd_en);
		end
	end

	assign rd_data = mem[rd_ptr_q];
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;

`ifndef ASSERT_OFF
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (cnt_q != CW'(DEPTH)) || rd_en)
		else $error("mid queue written while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (cnt_q != '0))
		else $error("mid queue read while empty");
`endif
endmodule
`default_nettype wire

// File: rtl/core/pws_front.sv
// Front end: three row dot products and the near-plane classification
`default_nettype none
module pws_front import pws_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int DEPTH = MID_DEPTH,
	localparam int RW = 66 - FRAC_BITS,
	localparam int EW = 1 + 3 * RW,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire point_t        point,
	output logic               full,
	input  wire coef_t         coef,
	input  wire logic [CW-1:0] mid_count,
	output logic               mid_wr,
	output logic      [EW-1:0] mid_data
);
	localparam longint NEAR_L = ((longint'(98) << FRAC_BITS) + 999) / 1000;
	localparam logic signed [RW-1:0] NEAR_Q = RW'(NEAR_L);
	localparam int OW = $clog2(DEPTH + 4);

	logic [31:0] cx [3];
	logic [31:0] cy [3];
	logic [31:0] cz [3];
	logic [31:0] co [3];

	logic               v_s1, v_s2, v_s3;
	logic signed [63:0] px_s1 [3];
	logic signed [63:0] py_s1 [3];
	logic signed [63:0] pz_s1 [3];
	logic        [31:0] off_s1 [3];
	logic signed [RW-1:0] pa_s2 [3];
	logic signed [RW-1:0] pb_s2 [3];
	logic signed [RW-1:0] row_s3 [3];
	logic [OW-1:0] occ;
	logic          take;

	always_comb begin
		cx[0] = coef.xa[31:0]; cy[0] = coef.xa[63:32];
		cz[0] = coef.xb[31:0]; co[0] = coef.xb[63:32];
		cx[1] = coef.ya[31:0]; cy[1] = coef.ya[63:32];
		cz[1] = coef.yb[31:0]; co[1] = coef.yb[63:32];
		cx[2] = coef.wa[31:0]; cy[2] = coef.wa[63:32];
		cz[2] = coef.wb[31:0]; co[2] = coef.wb[63:32];
	end

	// every item in flight holds a queue slot
	assign occ  = OW'(mid_count) + OW'(v_s1) + OW'(v_s2) + OW'(v_s3);
	assign full = (occ >= OW'(DEPTH));
	assign take = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			px_s1[r]  <= point.world_x * $signed(cx[r]);
			py_s1[r]  <= point.world_y * $signed(cy[r]);
			pz_s1[r]  <= point.world_z * $signed(cz[r]);
			off_s1[r] <= co[r];
			// floor each product to the fixed-point grid
			pa_s2[r] <= $signed({{2{px_s1[r][63]}}, px_s1[r][63:FRAC_BITS]})
				+ $signed({{2{py_s1[r][63]}}, py_s1[r][63:FRAC_BITS]});
			pb_s2[r] <= $signed({{2{pz_s1[r][63]}}, pz_s1[r][63:FRAC_BITS]})
				+ $signed({{(RW-32){off_s1[r][31]}}, off_s1[r]});
			row_s3[r] <= pa_s2[r] + pb_s2[r];
		end
	end

	assign mid_wr   = v_s3;
	assign mid_data = {(row_s3[2] >= NEAR_Q), row_s3[0], row_s3[1], row_s3[2]};
endmodule
`default_nettype wire

// File: rtl/core/pws_back.sv
// Back end: pipelined restoring dividers, half-size scaling and saturation
`default_nettype none
module pws_back import pws_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int RW = 66 - FRAC_BITS,
	localparam int EW = 1 + 3 * RW,
	localparam int QB = RATIO_BITS,
	localparam int SH = QB - FRAC_BITS,
	localparam int SW = QB + 3,
	localparam int MW = SW + HALF_W + 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              mid_empty,
	input  wire logic [EW-1:0]     mid_data,
	output logic                   mid_rd,
	input  wire logic [HALF_W-1:0] half_w,
	input  wire logic [HALF_W-1:0] half_h,
	output logic                   empty,
	input  wire logic              pop,
	output pixel_t                 pixel
);
	localparam logic signed [SW-1:0] ONE  = SW'(1) << FRAC_BITS;
	localparam logic signed [MW-1:0] SMAX = MW'(32'sh7fffffff);
	localparam logic signed [MW-1:0] SMIN = -(MW'(32'sh7fffffff)) - MW'(1);

	logic               en;
	logic               e_vis;
	logic signed [RW-1:0] e_xc, e_yc, e_w;
	logic [RW-1:0]      ax, ay, hx, hy;

	logic [QB:0]        v_d;
	logic [QB:0]        vis_d, nx_d, ny_d, clx_d, cly_d;
	logic [RW-2:0]      d_d  [QB+1];
	logic [RW-2:0]      rx_d [QB+1];
	logic [RW-2:0]      ry_d [QB+1];
	logic [QB-1:0]      nlx_d [QB+1];
	logic [QB-1:0]      nly_d [QB+1];
	logic [QB-1:0]      qx_d [QB+1];
	logic [QB-1:0]      qy_d [QB+1];

	logic               v_m, vis_m;
	logic signed [MW-1:0] px_m, py_m;
	logic [QB:0]        magx, magy;
	logic signed [SW-1:0] sx, sy;
	logic               out_v_q;
	pixel_t             out_q;

	assign en     = !out_v_q || pop;
	assign mid_rd = en && !mid_empty;

	assign {e_vis, e_xc, e_yc, e_w} = mid_data;
	assign ax = e_xc[RW-1] ? RW'(-e_xc) : RW'(e_xc);
	assign ay = e_yc[RW-1] ? RW'(-e_yc) : RW'(e_yc);
	assign hx = ax >> SH;
	assign hy = ay >> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d     <= '0;
			v_m     <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_d     <= {v_d[QB-1:0], !mid_empty};
			v_m     <= v_d[QB];
			out_v_q <= v_m;
		end
	end

	// entry: magnitudes, clamp test and the leading remainder
	always_ff @(posedge clk) begin
		if (en) begin
			vis_d[0] <= e_vis;
			nx_d[0]  <= e_xc[RW-1];
			ny_d[0]  <= e_yc[RW-1];
			d_d[0]   <= e_w[RW-2:0];
			clx_d[0] <= hx >= {1'b0, e_w[RW-2:0]};
			cly_d[0] <= hy >= {1'b0, e_w[RW-2:0]};
			rx_d[0]  <= hx[RW-2:0];
			ry_d[0]  <= hy[RW-2:0];
			nlx_d[0] <= {ax[SH-1:0], {FRAC_BITS{1'b0}}};
			nly_d[0] <= {ay[SH-1:0], {FRAC_BITS{1'b0}}};
			qx_d[0]  <= '0;
			qy_d[0]  <= '0;
		end
	end

	// one quotient bit per stage for each axis
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [RW-1:0] tx, ty, dfx, dfy;
		logic          gx, gy;

		assign tx  = {rx_d[k], nlx_d[k][QB-1]};
		assign ty  = {ry_d[k], nly_d[k][QB-1]};
		assign dfx = tx - {1'b0, d_d[k]};
		assign dfy = ty - {1'b0, d_d[k]};
		assign gx  = tx >= {1'b0, d_d[k]};
		assign gy  = ty >= {1'b0, d_d[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				vis_d[k+1] <= vis_d[k];
				nx_d[k+1]  <= nx_d[k];
				ny_d[k+1]  <= ny_d[k];
				clx_d[k+1] <= clx_d[k];
				cly_d[k+1] <= cly_d[k];
				d_d[k+1]   <= d_d[k];
				rx_d[k+1]  <= gx ? dfx[RW-2:0] : tx[RW-2:0];
				ry_d[k+1]  <= gy ? dfy[RW-2:0] : ty[RW-2:0];
				nlx_d[k+1] <= nlx_d[k] << 1;
				nly_d[k+1] <= nly_d[k] << 1;
				qx_d[k+1]  <= {qx_d[k][QB-2:0], gx};
				qy_d[k+1]  <= {qy_d[k][QB-2:0], gy};
			end
		end
	end

	assign magx = clx_d[QB] ? ((QB+1)'(1) << QB) : {1'b0, qx_d[QB]};
	assign magy = cly_d[QB] ? ((QB+1)'(1) << QB) : {1'b0, qy_d[QB]};
	assign sx   = nx_d[QB] ? ONE - $signed({2'b0, magx}) : ONE + $signed({2'b0, magx});
	assign sy   = ny_d[QB] ? ONE + $signed({2'b0, magy}) : ONE - $signed({2'b0, magy});

	always_ff @(posedge clk) begin
		if (en) begin
			vis_m <= vis_d[QB];
			px_m  <= MW'(sx) * $signed({{(MW-HALF_W){1'b0}}, half_w});
			py_m  <= MW'(sy) * $signed({{(MW-HALF_W){1'b0}}, half_h});
		end
	end

	function automatic logic signed [31:0] sat32(input logic signed [MW-1:0] v);
		logic signed [31:0] r;
		if (v > SMAX) begin
			r = 32'sh7fffffff;
		end else if (v < SMIN) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.visible  <= vis_m;
			out_q.screen_x <= vis_m ? sat32(px_m) : '0;
			out_q.screen_y <= vis_m ? sat32(py_m) : '0;
		end
	end

	assign empty = !out_v_q;
	assign pixel = out_q;

`ifndef ASSERT_OFF
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_q.visible) |-> (out_q.screen_x == '0) && (out_q.screen_y == '0))
		else $error("hidden point with nonzero screen position");
`endif
endmodule
`default_nettype wire

// File: rtl/core/perspective_world_to_screen.sv
// Top level: configuration registers, front end, mid queue and back end
//
//   channel   | signals                        | transfer when
//   ----------+--------------------------------+-----------------------
//   points    | push, full, point              | push && !full
//   pixels    | empty, pop, pixel              | pop && !empty
//   config    | cfg_we, cfg_addr, cfg_data     | cfg_we
//
// One point per cycle sustained while pixels are popped; a point passes the front
// stages, the mid queue, one entry stage, 40 divider stages (one quotient bit each),
// one multiply and one saturation stage. The divider pipeline is the longest part.
// Reset clears valid bits and loads default screen size; coefficients read 0.
// A held result stalls the back end; the front keeps going until the mid queue
// slots are all claimed, then raises full.
`default_nettype none
module perspective_world_to_screen import pws_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire point_t                point,
	output logic                       empty,
	input  wire logic                  pop,
	output pixel_t                     pixel,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int RW = 66 - FRAC_BITS;
	localparam int EW = 1 + 3 * RW;
	localparam int CW = $clog2(MID_DEPTH + 1);

	coef_t             coef_q;
	logic [HALF_W-1:0] half_w_q, half_h_q;
	logic              mid_wr, mid_rd, mid_empty;
	logic [EW-1:0]     mid_wdata, mid_rdata;
	logic [CW-1:0]     mid_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= '0;
			half_w_q <= HALF_W_RST;
			half_h_q <= HALF_H_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_XROW_A: coef_q.xa <= cfg_data;
				CFG_XROW_B: coef_q.xb <= cfg_data;
				CFG_YROW_A: coef_q.ya <= cfg_data;
				CFG_YROW_B: coef_q.yb <= cfg_data;
				CFG_WROW_A: coef_q.wa <= cfg_data;
				CFG_WROW_B: coef_q.wb <= cfg_data;
				CFG_HALF_W: half_w_q  <= cfg_data[HALF_W-1:0];
				CFG_HALF_H: half_h_q  <= cfg_data[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	pws_front #(.FRAC_BITS(FRAC_BITS), .DEPTH(MID_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.point     (point),
		.full      (full),
		.coef      (coef_q),
		.mid_count (mid_count),
		.mid_wr    (mid_wr),
		.mid_data  (mid_wdata)
	);

	pws_fifo #(.WIDTH(EW), .DEPTH(MID_DEPTH)) u_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_data (mid_wdata),
		.rd_en   (mid_rd),
		.rd_data (mid_rdata),
		.empty   (mid_empty),
		.count   (mid_count)
	);

	pws_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_data  (mid_rdata),
		.mid_rd    (mid_rd),
		.half_w    (half_w_q),
		.half_h    (half_h_q),
		.empty     (empty),
		.pop       (pop),
		.pixel     (pixel)
	);
endmodule
`default_nettype wire
